/* hw/rtl/bqc_pkg.sv */
// Shared constants, codes and types of the multichannel biquad cascade.
package bqc_pkg;

  // Default configuration of the filter bank
  localparam int NUM_CHANNELS_DEF = 8;
  localparam int NUM_STAGES_DEF   = 3;
  localparam int COEF_WIDTH_DEF   = 16;

  // Field widths
  localparam int CH_W    = 4;
  localparam int RAW_W   = 24;
  localparam int OUT_W   = 40;
  localparam int ST_W    = 48;
  localparam int STAT_W  = 2;
  localparam int GAIN_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Coefficient banks: four 64-bit registers, four 16-bit slots each
  localparam int BANK_CNT = 4;
  localparam int SLOT_W   = 16;
  localparam int BANKS_W  = BANK_CNT * CFG_W;

  // Shared multiplier operand widths and accumulator width
  localparam int MA_W  = OUT_W;
  localparam int MB_W  = SLOT_W + 1;
  localparam int ACC_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BANK0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BANK1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BANK2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BANK3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;

  // Reset values of the registers (pass-through stages)
  localparam logic [CFG_W-1:0]  BANK0_RST = 64'd16384;
  localparam logic [CFG_W-1:0]  BANK1_RST = 64'd1073741824;
  localparam logic [CFG_W-1:0]  BANK2_RST = 64'd70368744177664;
  localparam logic [CFG_W-1:0]  BANK3_RST = 64'd0;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 32'd6000000;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_CH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_CLR    = 2'd3;

  // Control from the sequencer to the state store
  typedef struct packed {
    logic clr;
    logic wr_z1;
    logic wr_z2;
  } st_ctrl_t;

endpackage

/* hw/rtl/bqc_mult.sv */
// Shared signed multiplier with a registered product.
module bqc_mult (
  input  logic                                            clk,
  input  logic signed [bqc_pkg::MA_W-1:0]                 mul_a,
  input  logic signed [bqc_pkg::MB_W-1:0]                 mul_b,
  output logic signed [bqc_pkg::MA_W+bqc_pkg::MB_W-1:0]   prod_r
);

  // Register the product for the accumulate step that follows
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

/* hw/rtl/bqc_state_store.sv */
// Per-channel, per-stage z1/z2 filter state with a clear of every entry at once.
module bqc_state_store #(
  parameter int DEPTH = bqc_pkg::NUM_CHANNELS_DEF * bqc_pkg::NUM_STAGES_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bqc_pkg::st_ctrl_t      st_ctrl,
  input  logic [IDX_W-1:0]       st_idx,
  input  logic signed [bqc_pkg::ST_W-1:0] st_wdata,
  output logic signed [bqc_pkg::ST_W-1:0] z1_rd,
  output logic signed [bqc_pkg::ST_W-1:0] z2_rd
);

  import bqc_pkg::*;

  logic signed [ST_W-1:0] z1_r [DEPTH];
  logic signed [ST_W-1:0] z2_r [DEPTH];

  // Clear everything on reset or clear command, else write one entry
  always_ff @(posedge clk) begin
    if (!rst_n || st_ctrl.clr) begin
      for (int i = 0; i < DEPTH; i++) begin
        z1_r[i] <= '0;
        z2_r[i] <= '0;
      end
    end else begin
      if (st_ctrl.wr_z1) begin
        z1_r[st_idx] <= st_wdata;
      end
      if (st_ctrl.wr_z2) begin
        z2_r[st_idx] <= st_wdata;
      end
    end
  end

  assign z1_rd = z1_r[st_idx];
  assign z2_rd = z2_r[st_idx];

endmodule

/* hw/rtl/bqc_core.sv */
// Sequencer and datapath: gain scaling and the biquad cascade on one multiplier.
module bqc_core #(
  parameter int NUM_CHANNELS = bqc_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_STAGES   = bqc_pkg::NUM_STAGES_DEF,
  parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF,
  parameter int DEPTH        = NUM_CHANNELS * NUM_STAGES,
  parameter int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item start
  input  logic                              start,
  input  logic                              cmd,
  input  logic [bqc_pkg::CH_W-1:0]          ch,
  input  logic signed [bqc_pkg::RAW_W-1:0]  raw,
  // configuration
  input  logic [bqc_pkg::BANKS_W-1:0]       coef_banks,
  input  logic [bqc_pkg::GAIN_W-1:0]        gain,
  // result
  output logic                              busy,
  output logic                              done,
  input  logic                              res_take,
  output logic [bqc_pkg::CH_W-1:0]          res_ch,
  output logic signed [bqc_pkg::OUT_W-1:0]  res_uv,
  output logic [bqc_pkg::STAT_W-1:0]        res_status,
  // state store
  output bqc_pkg::st_ctrl_t                 st_ctrl,
  output logic [IDX_W-1:0]                  st_idx,
  output logic signed [bqc_pkg::ST_W-1:0]   st_wdata,
  input  logic signed [bqc_pkg::ST_W-1:0]   z1_rd,
  input  logic signed [bqc_pkg::ST_W-1:0]   z2_rd
);

  import bqc_pkg::*;

  localparam int FB         = COEF_WIDTH - 2;
  localparam int GAIN_SHIFT = 12;
  localparam int GAIN_SPLIT = GAIN_W / 2;
  localparam int N_COEF     = 5;
  localparam int SG_W       = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int P_W        = MA_W + MB_W;

  // Coefficient positions within a stage
  localparam logic [2:0] K_B0 = 3'd0;
  localparam logic [2:0] K_B1 = 3'd1;
  localparam logic [2:0] K_B2 = 3'd2;
  localparam logic [2:0] K_A1 = 3'd3;
  localparam logic [2:0] K_A2 = 3'd4;

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_G0   = 4'd1;
  localparam logic [3:0] ST_G1   = 4'd2;
  localparam logic [3:0] ST_G2   = 4'd3;
  localparam logic [3:0] ST_G3   = 4'd4;
  localparam logic [3:0] ST_SA   = 4'd5;
  localparam logic [3:0] ST_SB   = 4'd6;
  localparam logic [3:0] ST_SC   = 4'd7;
  localparam logic [3:0] ST_SD   = 4'd8;
  localparam logic [3:0] ST_SE   = 4'd9;
  localparam logic [3:0] ST_SF   = 4'd10;
  localparam logic [3:0] ST_SG   = 4'd11;
  localparam logic [3:0] ST_DONE = 4'd12;

  // Round to nearest, ties up: add half, then floor shift
  function automatic logic signed [ACC_W-1:0] rnd_shift(
      input logic signed [ACC_W-1:0] v, input int unsigned k);
    logic signed [ACC_W-1:0] t;
    t = v + $signed(ACC_W'(1) << (k - 1));
    return t >>> k;
  endfunction

  // Clamp to a signed range of the given width
  function automatic logic signed [ACC_W-1:0] sat_clamp(
      input logic signed [ACC_W-1:0] v, input int unsigned bits);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed((ACC_W'(1) << (bits - 1)) - ACC_W'(1));
    lo = ~hi;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Low COEF_WIDTH bits of a slot, sign-extended to the multiplier width
  function automatic logic signed [MB_W-1:0] coef_at(
      input logic [BANKS_W-1:0] banks, input logic [3:0] slot);
    logic [SLOT_W-1:0] field;
    logic [MB_W-1:0]   mask;
    logic [MB_W-1:0]   v;
    field = banks[slot*SLOT_W +: SLOT_W];
    mask  = MB_W'((MB_W'(1) << COEF_WIDTH) - MB_W'(1));
    v     = {1'b0, field} & mask;
    if (field[COEF_WIDTH-1]) v = v | ~mask;
    return $signed(v);
  endfunction

  logic [3:0]              state_r, state_nxt;
  logic [CH_W-1:0]         ch_r, ch_nxt;
  logic signed [RAW_W-1:0] raw_r, raw_nxt;
  logic signed [OUT_W-1:0] x_r, x_nxt;
  logic signed [OUT_W-1:0] y_r, y_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] acc2_r, acc2_nxt;
  logic [SG_W-1:0]         stage_r, stage_nxt;
  logic                    sat_r, sat_nxt;
  logic signed [OUT_W-1:0] res_uv_r, res_uv_nxt;
  logic [STAT_W-1:0]       status_r, status_nxt;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [MA_W-1:0]  raw_ext;
  logic signed [ACC_W-1:0] z1_ext;
  logic signed [ACC_W-1:0] z2_ext;
  logic signed [ACC_W-1:0] rnd1;
  logic signed [ACC_W-1:0] rnd2;
  logic signed [ACC_W-1:0] out_sat1;
  logic signed [ACC_W-1:0] st_sat1;
  logic signed [ACC_W-1:0] st_sat2;
  logic                    out_ovf1;
  logic                    st_ovf1;
  logic                    st_ovf2;
  logic [2:0]              coef_k;
  logic [3:0]              slot;
  logic signed [MB_W-1:0]  coef_val;
  logic [7:0]              idx_full;
  logic                    ch_ok_in;
  logic                    last_stage;

  bqc_mult u_mult (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Widen operands and stored state to the accumulator
  assign prod_ext = {{(ACC_W-P_W){prod_r[P_W-1]}}, prod_r};
  assign raw_ext  = {{(MA_W-RAW_W){raw_r[RAW_W-1]}}, raw_r};
  assign z1_ext   = {{(ACC_W-ST_W){z1_rd[ST_W-1]}}, z1_rd} <<< FB;
  assign z2_ext   = {{(ACC_W-ST_W){z2_rd[ST_W-1]}}, z2_rd} <<< FB;

  // Round and clamp the accumulators
  assign rnd1     = rnd_shift(acc_r, (state_r == ST_G3) ? GAIN_SHIFT : FB);
  assign rnd2     = rnd_shift(acc2_r, FB);
  assign out_sat1 = sat_clamp(rnd1, OUT_W);
  assign st_sat1  = sat_clamp(rnd1, ST_W);
  assign st_sat2  = sat_clamp(rnd2, ST_W);
  assign out_ovf1 = (out_sat1 != rnd1);
  assign st_ovf1  = (st_sat1 != rnd1);
  assign st_ovf2  = (st_sat2 != rnd2);

  // State entry of the current channel and stage
  assign idx_full   = 8'(ch_r) * 8'(NUM_STAGES) + 8'(stage_r);
  assign st_idx     = idx_full[IDX_W-1:0];
  assign ch_ok_in   = ({1'b0, ch} < (CH_W+1)'(NUM_CHANNELS));
  assign last_stage = (stage_r == SG_W'(NUM_STAGES - 1));

  // Pick the coefficient that this step multiplies by
  always_comb begin
    unique case (state_r)
      ST_SB:   coef_k = K_B1;
      ST_SC:   coef_k = K_B2;
      ST_SD:   coef_k = K_A1;
      ST_SE:   coef_k = K_A2;
      default: coef_k = K_B0;
    endcase
  end

  assign slot     = 4'(8'(stage_r) * 8'(N_COEF) + 8'(coef_k));
  assign coef_val = coef_at(coef_banks, slot);

  // Steer the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_G0: begin
        mul_a = raw_ext;
        mul_b = $signed({1'b0, gain[GAIN_W-1:GAIN_SPLIT]});
      end
      ST_G1: begin
        mul_a = raw_ext;
        mul_b = $signed({1'b0, gain[GAIN_SPLIT-1:0]});
      end
      ST_SA, ST_SB, ST_SC: begin
        mul_a = x_r;
        mul_b = coef_val;
      end
      ST_SD, ST_SE: begin
        mul_a = y_r;
        mul_b = coef_val;
      end
      default: ;
    endcase
  end

  // Sequence: scale in two partial products, then seven steps per stage
  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    raw_nxt    = raw_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    acc2_nxt   = acc2_r;
    stage_nxt  = stage_r;
    sat_nxt    = sat_r;
    res_uv_nxt = res_uv_r;
    status_nxt = status_r;
    st_ctrl    = '0;
    st_wdata   = st_sat1[ST_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ch_nxt     = ch;
          raw_nxt    = raw;
          sat_nxt    = 1'b0;
          stage_nxt  = '0;
          res_uv_nxt = '0;
          if (cmd) begin
            st_ctrl.clr = 1'b1;
            status_nxt  = STAT_CLR;
            state_nxt   = ST_DONE;
          end else if (!ch_ok_in) begin
            status_nxt = STAT_BAD_CH;
            state_nxt  = ST_DONE;
          end else begin
            state_nxt = ST_G0;
          end
        end
      end
      ST_G0: state_nxt = ST_G1;
      ST_G1: begin
        acc_nxt   = prod_ext <<< GAIN_SPLIT;
        state_nxt = ST_G2;
      end
      ST_G2: begin
        acc_nxt   = acc_r + prod_ext;
        state_nxt = ST_G3;
      end
      ST_G3: begin
        x_nxt     = out_sat1[OUT_W-1:0];
        sat_nxt   = sat_r | out_ovf1;
        state_nxt = ST_SA;
      end
      ST_SA: begin
        acc_nxt   = z1_ext;
        state_nxt = ST_SB;
      end
      ST_SB: begin
        acc_nxt   = acc_r + prod_ext;
        state_nxt = ST_SC;
      end
      ST_SC: begin
        y_nxt     = out_sat1[OUT_W-1:0];
        sat_nxt   = sat_r | out_ovf1;
        acc_nxt   = z2_ext + prod_ext;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        acc2_nxt  = prod_ext;
        state_nxt = ST_SE;
      end
      ST_SE: begin
        acc_nxt   = acc_r - prod_ext;
        state_nxt = ST_SF;
      end
      ST_SF: begin
        st_ctrl.wr_z1 = 1'b1;
        st_wdata      = st_sat1[ST_W-1:0];
        sat_nxt       = sat_r | st_ovf1;
        acc2_nxt      = acc2_r - prod_ext;
        state_nxt     = ST_SG;
      end
      ST_SG: begin
        st_ctrl.wr_z2 = 1'b1;
        st_wdata      = st_sat2[ST_W-1:0];
        sat_nxt       = sat_r | st_ovf2;
        x_nxt         = y_r;
        if (last_stage) begin
          res_uv_nxt = y_r;
          status_nxt = (sat_r | st_ovf2) ? STAT_SAT : STAT_OK;
          state_nxt  = ST_DONE;
        end else begin
          stage_nxt = stage_r + 1'b1;
          state_nxt = ST_SA;
        end
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    raw_r    <= raw_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    acc_r    <= acc_nxt;
    acc2_r   <= acc2_nxt;
    stage_r  <= stage_nxt;
    sat_r    <= sat_nxt;
    res_uv_r <= res_uv_nxt;
    status_r <= status_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign done       = (state_r == ST_DONE);
  assign res_ch     = ch_r;
  assign res_uv     = res_uv_r;
  assign res_status = status_r;

  // A new item only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
      start |-> (state_r == ST_IDLE))
    else $error("item started while sequencer busy");

  // A clear command finishes at once with the cleared status
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
      (start && cmd) |=> (state_r == ST_DONE && status_r == STAT_CLR))
    else $error("clear command did not report cleared status");

  // State of an out-of-range channel is never written
  a_no_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
      (st_ctrl.wr_z1 || st_ctrl.wr_z2) |-> ({1'b0, ch_r} < (CH_W+1)'(NUM_CHANNELS)))
    else $error("state write for channel out of range");

  // A finished result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_DONE && !res_take) |=>
      (state_r == ST_DONE && $stable(res_uv_r) && $stable(status_r)))
    else $error("finished result changed before it was taken");

endmodule

/* hw/rtl/multichannel_biquad_cascade_unit.sv */
// Top level: configuration registers, handshake and output register of the biquad cascade.
//
// Multichannel cascaded biquad filter, transposed direct form II, in fixed point.
// Each beat on the input carries a command, a channel and a signed 24-bit sample;
// a filter command scales the sample to microvolts (Q24.16) and runs it through
// NUM_STAGES biquads with per-channel z1/z2 state, and every beat gives exactly
// one result beat. A clear command or an out-of-range channel goes straight to
// its result; a filter command on a valid channel is paced by the single
// shared 40x17 multiplier: the gain product is formed in two halves and each
// stage makes its five coefficient products one after another, with rounding
// and saturation steps in between. The input stalls until the current item's
// result sits in the output register, which holds one finished beat while the
// next item is worked on. Coefficient and gain writes take effect at once and
// belong between items.
module multichannel_biquad_cascade_unit #(
  parameter int NUM_CHANNELS = bqc_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_STAGES   = bqc_pkg::NUM_STAGES_DEF,
  parameter int COEF_WIDTH   = bqc_pkg::COEF_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bqc_pkg::CFG_W-1:0]         cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [bqc_pkg::CH_W-1:0]          in_channel,
  input  logic signed [bqc_pkg::RAW_W-1:0]  in_raw_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bqc_pkg::CH_W-1:0]          out_channel_out,
  output logic signed [bqc_pkg::OUT_W-1:0]  out_filtered_uv,
  output logic [bqc_pkg::STAT_W-1:0]        out_status
);

  import bqc_pkg::*;

  localparam int DEPTH = NUM_CHANNELS * NUM_STAGES;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]        bank_r [BANK_CNT];
  logic [GAIN_W-1:0]       gain_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [OUT_W-1:0] out_uv_r;
  logic [STAT_W-1:0]       out_stat_r;

  logic                    start;
  logic                    core_busy;
  logic                    core_done;
  logic                    res_take;
  logic [CH_W-1:0]         res_ch;
  logic signed [OUT_W-1:0] res_uv;
  logic [STAT_W-1:0]       res_status;
  st_ctrl_t                st_ctrl;
  logic [IDX_W-1:0]        st_idx;
  logic signed [ST_W-1:0]  st_wdata;
  logic signed [ST_W-1:0]  z1_rd;
  logic signed [ST_W-1:0]  z2_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r[0] <= BANK0_RST;
      bank_r[1] <= BANK1_RST;
      bank_r[2] <= BANK2_RST;
      bank_r[3] <= BANK3_RST;
      gain_r    <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEFF_BANK0: bank_r[0] <= cfg_wdata;
        REG_COEFF_BANK1: bank_r[1] <= cfg_wdata;
        REG_COEFF_BANK2: bank_r[2] <= cfg_wdata;
        REG_COEFF_BANK3: bank_r[3] <= cfg_wdata;
        REG_GAIN:        gain_r    <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept a beat whenever the sequencer is idle
  assign in_stall = core_busy;
  assign start    = in_valid && !in_stall;

  bqc_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_STAGES   (NUM_STAGES),
    .COEF_WIDTH   (COEF_WIDTH),
    .DEPTH        (DEPTH),
    .IDX_W        (IDX_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .cmd        (in_cmd),
    .ch         (in_channel),
    .raw        (in_raw_sample),
    .coef_banks ({bank_r[3], bank_r[2], bank_r[1], bank_r[0]}),
    .gain       (gain_r),
    .busy       (core_busy),
    .done       (core_done),
    .res_take   (res_take),
    .res_ch     (res_ch),
    .res_uv     (res_uv),
    .res_status (res_status),
    .st_ctrl    (st_ctrl),
    .st_idx     (st_idx),
    .st_wdata   (st_wdata),
    .z1_rd      (z1_rd),
    .z2_rd      (z2_rd)
  );

  bqc_state_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .st_ctrl  (st_ctrl),
    .st_idx   (st_idx),
    .st_wdata (st_wdata),
    .z1_rd    (z1_rd),
    .z2_rd    (z2_rd)
  );

  // Move a finished result into the output register when it is free
  assign res_take = core_done && (!out_valid_r || !out_stall);

  always_comb begin
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until the beat is taken
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_ch_r   <= res_ch;
      out_uv_r   <= res_uv;
      out_stat_r <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_filtered_uv = out_uv_r;
  assign out_status      = out_stat_r;

endmodule
